// ===== rtl/core/move_to_front_coder_macros.svh =====
// assertion macros for the move-to-front coder
// used by the top level; expects clk and rst in scope
`ifndef MOVE_TO_FRONT_CODER_MACROS_SVH
`define MOVE_TO_FRONT_CODER_MACROS_SVH

// same-cycle implication
`define MTF_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("move_to_front_coder: same-cycle check failed");

// next-cycle implication
`define MTF_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("move_to_front_coder: next-cycle check failed");

`endif

// ===== rtl/core/mtf_pkg.sv =====
// shared types and constants for the move-to-front coder
// used by mtf_cell, mtf_gather and move_to_front_coder
`default_nettype none

package mtf_pkg;

  localparam int ALPHA_SIZE = 96;
  localparam int SYM_W      = 8;
  localparam int RANK_W     = 7;
  localparam int GROUPS     = 8;
  localparam int GROUP_SIZE = ALPHA_SIZE / GROUPS;

  localparam logic [SYM_W-1:0] FIRST_PRINTABLE = 8'h20;
  localparam logic [SYM_W-1:0] NEWLINE_CHAR    = 8'h0A;

  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [RANK_W-1:0] rank_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic  restore;
    logic  compare;
    logic  mode;
    sym_t  sym;
    rank_t rank;
    logic  move;
    rank_t pos;
  } mtf_ctrl_t;

  // result of the gather tree
  typedef struct packed {
    logic  found;
    rank_t pos;
    sym_t  picked;
  } mtf_pick_t;

  function automatic sym_t init_symbol(input int idx);
    sym_t s;
    if (idx == ALPHA_SIZE - 1) begin
      s = NEWLINE_CHAR;
    end else begin
      s = FIRST_PRINTABLE + SYM_W'(idx);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/move_to_front_coder.sv =====
// move-to-front coder over a 96-symbol alphabet (space..tilde, newline)
// top level; depends on mtf_pkg, mtf_cell, mtf_gather and the macro header
//
// input word (in_valid/in_ready): mode, start_of_block, symbol_in, rank_in.
// output word (out_valid/out_ready): rank_out, symbol_out, miss.
// mode 0 encodes symbol_in to its current rank, mode 1 decodes rank_in to
// the symbol held there; in both modes the used entry then moves to rank 0.
// start_of_block restores the initial order before the word is worked on.
// an unknown symbol or a rank of 96 or more sets miss and keeps the table.
// the table is a row of 96 cells; each cell compares its own entry in
// parallel and takes its left neighbor's entry on a move.
// the result passes the match step, the two stages of the gather tree and the
// shift step before it is registered; one word is in flight, and a new word is
// accepted only once the last one has left the shift step.
// reset puts the table in initial order and empties the output register.
// a stalled receiver holds the result; the next word is accepted while it
// waits, and its own result waits in the shift step until the output frees.
`default_nettype none

module move_to_front_coder (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          mode,
  input  wire logic          start_of_block,
  input  wire logic [7:0]    symbol_in,
  input  wire logic [6:0]    rank_in,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [6:0]         rank_out,
  output logic [7:0]         symbol_out,
  output logic               miss
);
  import mtf_pkg::*;

  `include "move_to_front_coder_macros.svh"

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MATCH  = 5'b00010,
    S_GROUP  = 5'b00100,
    S_GATHER = 5'b01000,
    S_MOVE   = 5'b10000
  } state_t;

  state_t    state;
  state_t    state_next;
  logic      mode_r;
  sym_t      sym_r;
  rank_t     rank_r;
  mtf_ctrl_t ctrl;
  mtf_pick_t pick;
  logic      in_fire;
  logic      emit;
  logic [ALPHA_SIZE-1:0] hit;
  sym_t      cell_value [ALPHA_SIZE];

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign emit     = (state == S_MOVE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_fire) begin
                  state_next = S_MATCH;
                end
      S_MATCH:  state_next = S_GROUP;
      S_GROUP:  state_next = S_GATHER;
      S_GATHER: state_next = S_MOVE;
      S_MOVE:   if (emit) begin
                  state_next = S_IDLE;
                end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= mode;
      sym_r  <= symbol_in;
      rank_r <= rank_in;
    end
  end

  always_comb begin
    ctrl.restore = in_fire && start_of_block;
    ctrl.compare = (state == S_MATCH);
    ctrl.mode    = mode_r;
    ctrl.sym     = sym_r;
    ctrl.rank    = rank_r;
    ctrl.move    = emit && pick.found;
    ctrl.pos     = pick.pos;
  end

  for (genvar k = 0; k < ALPHA_SIZE; k++) begin : g_cell
    mtf_cell #(.INDEX(k)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .left  ((k == 0) ? pick.picked : cell_value[(k == 0) ? 0 : k-1]),
      .value (cell_value[k]),
      .hit   (hit[k])
    );
  end

  mtf_gather u_gather (
    .clk    (clk),
    .hit    (hit),
    .values (cell_value),
    .pick   (pick)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rank_out   <= (!mode_r && pick.found) ? pick.pos : '0;
      symbol_out <= (mode_r && pick.found) ? pick.picked : '0;
      miss       <= !pick.found;
    end
  end

  // the table is a permutation, so at most one cell matches
  `MTF_ASSERT_NOW(a_single_hit, state == S_GROUP, $onehot0(hit))
  `MTF_ASSERT_NOW(a_decode_pos, (state == S_MOVE) && mode_r && pick.found, pick.pos == rank_r)
  `MTF_ASSERT_NOW(a_encode_sym, (state == S_MOVE) && !mode_r && pick.found, pick.picked == sym_r)
  `MTF_ASSERT_NEXT(a_front_load, ctrl.move, cell_value[0] == $past(pick.picked))

endmodule

`default_nettype wire

// ===== rtl/core/mtf_cell.sv =====
// one table position: holds a symbol, matches it, shifts from its left neighbor
// depends on mtf_pkg
`default_nettype none

module mtf_cell #(
  parameter int INDEX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mtf_pkg::mtf_ctrl_t ctrl,
  input  wire mtf_pkg::sym_t     left,
  output mtf_pkg::sym_t          value,
  output logic                   hit
);
  import mtf_pkg::*;

  localparam rank_t IDX  = RANK_W'(INDEX);
  localparam sym_t  INIT = init_symbol(INDEX);

  always_ff @(posedge clk) begin
    if (rst || ctrl.restore) begin
      value <= INIT;
    end else if (ctrl.move && (IDX <= ctrl.pos)) begin
      value <= left;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      hit <= ctrl.mode ? (IDX == ctrl.rank) : (value == ctrl.sym);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mtf_gather.sv =====
// two-stage registered or-tree that collects the matching cell's rank and symbol
// depends on mtf_pkg
`default_nettype none

module mtf_gather (
  input  wire logic                 clk,
  input  wire logic [mtf_pkg::ALPHA_SIZE-1:0] hit,
  input  wire mtf_pkg::sym_t        values [mtf_pkg::ALPHA_SIZE],
  output mtf_pkg::mtf_pick_t        pick
);
  import mtf_pkg::*;

  logic  grp_found      [GROUPS];
  rank_t grp_rank       [GROUPS];
  sym_t  grp_sym        [GROUPS];
  logic  grp_found_next [GROUPS];
  rank_t grp_rank_next  [GROUPS];
  sym_t  grp_sym_next   [GROUPS];
  mtf_pick_t pick_next;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_found_next[g] = 1'b0;
      grp_rank_next[g]  = '0;
      grp_sym_next[g]   = '0;
      for (int i = 0; i < GROUP_SIZE; i++) begin
        if (hit[g*GROUP_SIZE + i]) begin
          grp_found_next[g] = 1'b1;
          grp_rank_next[g]  = grp_rank_next[g] | RANK_W'(g*GROUP_SIZE + i);
          grp_sym_next[g]   = grp_sym_next[g] | values[g*GROUP_SIZE + i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_found[g] <= grp_found_next[g];
      grp_rank[g]  <= grp_rank_next[g];
      grp_sym[g]   <= grp_sym_next[g];
    end
  end

  always_comb begin
    pick_next = '0;
    for (int g = 0; g < GROUPS; g++) begin
      pick_next.found  = pick_next.found | grp_found[g];
      pick_next.pos    = pick_next.pos | grp_rank[g];
      pick_next.picked = pick_next.picked | grp_sym[g];
    end
  end

  always_ff @(posedge clk) begin
    pick <= pick_next;
  end

endmodule

`default_nettype wire

// ===== test/move_to_front_coder_test.sv =====
// self-checking testbench for move_to_front_coder: random and directed words
// checked against a move-to-front predictor; depends on mtf_pkg and the rtl
`default_nettype none

module move_to_front_coder_test;

  localparam bit MODE_ENCODE = 1'b0;
  localparam bit MODE_DECODE = 1'b1;
  localparam int ALPHA       = mtf_pkg::ALPHA_SIZE;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    bit       mode;
    bit       sob;
    bit [7:0] sym;
    bit [6:0] rank;
  } mtf_word_t;

  typedef struct packed {
    bit [6:0] rank;
    bit [7:0] sym;
    bit       miss;
  } mtf_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       mode = 1'b0;
  logic       start_of_block = 1'b0;
  logic [7:0] symbol_in = 8'h00;
  logic [6:0] rank_in = 7'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] rank_out;
  logic [7:0] symbol_out;
  logic       miss;

  mtf_pkg::sym_t order_now [ALPHA];
  mtf_word_t     pending_q [$];
  mtf_result_t   expected_q [$];

  int  words_taken = 0;
  int  results_seen = 0;
  int  misses_seen = 0;
  int  encodes = 0;
  int  decodes = 0;
  int  restarts = 0;
  int  errors = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  logic calm;

  assign calm = words_taken >= 250 && words_taken < 450;

  move_to_front_coder dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .start_of_block (start_of_block),
    .symbol_in      (symbol_in),
    .rank_in        (rank_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .rank_out       (rank_out),
    .symbol_out     (symbol_out),
    .miss           (miss)
  );

  always #5 clk = ~clk;

  function automatic mtf_pkg::sym_t alphabet_char(input int idx);
    if (idx == ALPHA - 1) begin
      return mtf_pkg::NEWLINE_CHAR;
    end
    return 8'h20 + 8'(idx);
  endfunction

  function automatic void restore_order();
    for (int k = 0; k < ALPHA; k++) begin
      order_now[k] = alphabet_char(k);
    end
  endfunction

  // look up, move to front, and return the expected result word
  function automatic mtf_result_t code_word(input mtf_word_t w);
    mtf_result_t   r;
    int            pos;
    mtf_pkg::sym_t picked;
    r = '0;
    pos = -1;
    if (w.sob) begin
      restore_order();
    end
    if (w.mode == MODE_ENCODE) begin
      for (int k = 0; k < ALPHA; k++) begin
        if (pos < 0 && order_now[k] == w.sym) begin
          pos = k;
        end
      end
    end else if (w.rank < ALPHA) begin
      pos = w.rank;
    end
    if (pos < 0) begin
      r.miss = 1'b1;
    end else begin
      picked = order_now[pos];
      if (w.mode == MODE_ENCODE) begin
        r.rank = 7'(pos);
      end else begin
        r.sym = picked;
      end
      for (int j = pos; j > 0; j--) begin
        order_now[j] = order_now[j-1];
      end
      order_now[0] = picked;
    end
    return r;
  endfunction

  task automatic push_word(input bit m, input bit s, input bit [7:0] sy, input bit [6:0] rk);
    mtf_word_t w;
    w = '{mode: m, sob: s, sym: sy, rank: rk};
    pending_q.insert(pending_q.size(), w);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (errors < PRINT_CAP) begin
      $display("mismatch at %0t, result %0d: %s got %h expected %h",
               $time, results_seen, what, got, want);
    end
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (pending_q[0].mode == MODE_ENCODE) encodes++; else decodes++;
        if (pending_q[0].sob) restarts++;
        expected_q.insert(expected_q.size(), code_word(pending_q.pop_front()));
        words_taken++;
      end
      if (in_valid && !in_ready) begin
        // hold the offered word
      end else if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
        in_valid       <= 1'b1;
        mode           <= pending_q[0].mode;
        start_of_block <= pending_q[0].sob;
        symbol_in      <= pending_q[0].sym;
        rank_in        <= pending_q[0].rank;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && words_taken >= 600) begin
        hold_left <= 150;
        hold_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      out_ready <= hold_left == 0 && (calm || $urandom_range(99) >= 9);
    end
  end

  // monitor
  always @(posedge clk) begin
    mtf_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("word with nothing expected, symbol_out", symbol_out, 8'h00);
      end else begin
        want = expected_q.pop_front();
        if (rank_out !== want.rank) report_mismatch("rank_out", {1'b0, rank_out}, {1'b0, want.rank});
        if (symbol_out !== want.sym) report_mismatch("symbol_out", symbol_out, want.sym);
        if (miss !== want.miss) report_mismatch("miss", {7'h00, miss}, {7'h00, want.miss});
        if (want.miss) misses_seen++;
      end
      results_seen++;
    end
  end

  initial begin
    #3_000_000;
    $display("move_to_front_coder_test: FAIL");
    $finish;
  end

  initial begin
    bit       m;
    bit       s;
    bit [7:0] sy;
    bit [6:0] rk;
    restore_order();

    // directed words
    push_word(MODE_ENCODE, 1'b1, 8'h20, 7'h7F);
    push_word(MODE_ENCODE, 1'b0, 8'h7E, 7'h00);
    push_word(MODE_ENCODE, 1'b0, 8'h0A, 7'h55);
    push_word(MODE_ENCODE, 1'b0, 8'h0A, 7'h2A);
    push_word(MODE_ENCODE, 1'b0, 8'h00, 7'h7F);
    push_word(MODE_ENCODE, 1'b0, 8'hFF, 7'h7F);
    push_word(MODE_ENCODE, 1'b0, 8'h7F, 7'h00);
    push_word(MODE_ENCODE, 1'b0, 8'h1F, 7'h00);
    push_word(MODE_ENCODE, 1'b0, 8'h09, 7'h00);
    push_word(MODE_DECODE, 1'b0, 8'hFF, 7'd0);
    push_word(MODE_DECODE, 1'b0, 8'h00, 7'd95);
    push_word(MODE_DECODE, 1'b0, 8'hFF, 7'd96);
    push_word(MODE_DECODE, 1'b0, 8'h00, 7'd127);
    push_word(MODE_DECODE, 1'b0, 8'h55, 7'd1);
    push_word(MODE_ENCODE, 1'b1, 8'h80, 7'h00);
    push_word(MODE_DECODE, 1'b0, 8'hAA, 7'd95);
    push_word(MODE_DECODE, 1'b1, 8'h00, 7'd127);
    push_word(MODE_ENCODE, 1'b0, 8'h7E, 7'h00);
    push_word(MODE_DECODE, 1'b0, 8'h00, 7'd0);
    push_word(MODE_ENCODE, 1'b0, 8'h41, 7'h7F);

    // random words, mostly valid symbols and ranks near the front
    for (int n = 0; n < 880; n++) begin
      m  = 1'($urandom_range(1));
      s  = $urandom_range(39) == 0;
      sy = 8'($urandom_range(255));
      rk = 7'($urandom_range(127));
      if ($urandom_range(9) != 0) begin
        if (m == MODE_ENCODE) begin
          sy = alphabet_char($urandom_range(1) ? $urandom_range(7) : $urandom_range(ALPHA - 1));
        end else begin
          rk = 7'($urandom_range(1) ? $urandom_range(7) : $urandom_range(ALPHA - 1));
        end
      end else if (m == MODE_DECODE) begin
        rk = 7'($urandom_range(127, ALPHA));
      end
      push_word(m, s, sy, rk);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending_q.size() != 0 || expected_q.size() != 0);
    repeat (20) @(posedge clk);

    $display("covered %0d encode and %0d decode words, %0d block restarts",
             encodes, decodes, restarts);
    $display("checked %0d results, %0d of them misses, %0d mismatches",
             results_seen, misses_seen, errors);
    if (errors == 0) begin
      $display("move_to_front_coder_test: PASS");
    end else begin
      $display("move_to_front_coder_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
